FILE: hdl/pfc_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph cipher.
// Used by every module of the block; depends on nothing else.
package pfc_pkg;

    localparam int unsigned SQ_DIM     = 5;   // square is SQ_DIM x SQ_DIM
    localparam int unsigned LETTER_W   = 5;   // letter code width
    localparam int unsigned POS_W      = 3;   // row / column index width
    localparam int unsigned ROW_W      = SQ_DIM * LETTER_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = ROW_W;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef logic [LETTER_W-1:0]  letter_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef row_t [SQ_DIM-1:0]    square_t;

    // Letter codes used by the cipher rules
    localparam letter_t LETTER_X = letter_t'(23);
    localparam letter_t LETTER_J = letter_t'(9);
    localparam letter_t LETTER_I = letter_t'(8);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECRYPT_MODE = 3'd0,
        CFG_SQUARE_ROW0  = 3'd1,
        CFG_SQUARE_ROW1  = 3'd2,
        CFG_SQUARE_ROW2  = 3'd3,
        CFG_SQUARE_ROW3  = 3'd4,
        CFG_SQUARE_ROW4  = 3'd5
    } cfg_reg_t;

    // Reset key square
    localparam row_t SQUARE_ROW0_RST = row_t'(4294688);
    localparam row_t SQUARE_ROW1_RST = row_t'(10755269);
    localparam row_t SQUARE_ROW2_RST = row_t'(16201099);
    localparam row_t SQUARE_ROW3_RST = row_t'(21613104);
    localparam row_t SQUARE_ROW4_RST = row_t'(27025109);

    // Located positions of both letters, carried from front to back
    typedef struct packed {
        pos_t row_a;
        pos_t col_a;
        pos_t row_b;
        pos_t col_b;
    } pair_pos_t;

    // Letter stored at one square position
    function automatic letter_t square_cell(square_t sq, pos_t r, pos_t c);
        return sq[r][LETTER_W*c +: LETTER_W];
    endfunction

    // Neighbor position with wrap: forward when encrypting, back when decrypting
    function automatic pos_t step_pos(pos_t p, logic dec);
        pos_t res;
        if (dec) begin
            res = (p == '0) ? pos_t'(SQ_DIM - 1) : p - 1'b1;
        end else begin
            res = (p == pos_t'(SQ_DIM - 1)) ? '0 : p + 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: hdl/pfc_front.sv
// Front part: accepts letter pairs, prepares the pair and locates both letters.
// Depends on pfc_pkg; feeds pfc_queue.
module pfc_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  pfc_pkg::letter_t    s_first_letter,
    input  pfc_pkg::letter_t    s_second_letter,
    input  logic                s_lone_letter,
    input  logic                decrypt_mode,
    input  pfc_pkg::square_t    square,
    input  logic                q_full,
    output logic                q_push,
    output pfc_pkg::pair_pos_t  q_wdata
);

    // Position of a letter; last match in row-major order, j looked up as i
    function automatic logic [2*pfc_pkg::POS_W-1:0] locate(pfc_pkg::square_t sq,
                                                           pfc_pkg::letter_t l);
        pfc_pkg::letter_t key;
        pfc_pkg::pos_t    r_f;
        pfc_pkg::pos_t    c_f;
        key = (l == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : l;
        r_f = '0;
        c_f = '0;
        for (int r = 0; r < pfc_pkg::SQ_DIM; r++) begin
            for (int c = 0; c < pfc_pkg::SQ_DIM; c++) begin
                if (sq[r][pfc_pkg::LETTER_W*c +: pfc_pkg::LETTER_W] == key) begin
                    r_f = pfc_pkg::POS_W'(r);
                    c_f = pfc_pkg::POS_W'(c);
                end
            end
        end
        return {r_f, c_f};
    endfunction

    pfc_pkg::letter_t second_prep;

    // Pair preparation: pad a lone letter and break doubled letters (encrypt only)
    always_comb begin
        second_prep = s_second_letter;
        if (!decrypt_mode) begin
            if (s_lone_letter) begin
                second_prep = pfc_pkg::LETTER_X;
            end
            if (s_first_letter == second_prep) begin
                second_prep = pfc_pkg::LETTER_X;
            end
        end
    end

    // Square lookup for both letters
    assign {q_wdata.row_a, q_wdata.col_a} = locate(square, s_first_letter);
    assign {q_wdata.row_b, q_wdata.col_b} = locate(square, second_prep);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

FILE: hdl/pfc_queue.sv
// Short FIFO of located pairs between front and back.
// Depends on pfc_pkg.
module pfc_queue #(
    parameter int unsigned DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pfc_pkg::pair_pos_t  wdata,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output pfc_pkg::pair_pos_t  rdata
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    pfc_pkg::pair_pos_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: hdl/pfc_back.sv
// Back part: applies the row, column or rectangle rule and holds the result.
// Depends on pfc_pkg; reads pairs from pfc_queue.
module pfc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                decrypt_mode,
    input  pfc_pkg::square_t    square,
    input  logic                q_not_empty,
    input  pfc_pkg::pair_pos_t  q_rdata,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output pfc_pkg::letter_t    m_out_first,
    output pfc_pkg::letter_t    m_out_second
);

    logic             m_valid_reg, m_valid_next;
    pfc_pkg::letter_t out_first_reg,  out_first_next;
    pfc_pkg::letter_t out_second_reg, out_second_next;
    pfc_pkg::letter_t res_first, res_second;
    pfc_pkg::pair_pos_t p;

    assign p = q_rdata;

    // Cipher rules; column rule overrides row rule for coinciding cells
    always_comb begin
        res_first  = pfc_pkg::square_cell(square, p.row_a, p.col_b);
        res_second = pfc_pkg::square_cell(square, p.row_b, p.col_a);
        if (p.row_a == p.row_b) begin
            res_first  = pfc_pkg::square_cell(square, p.row_a,
                                              pfc_pkg::step_pos(p.col_a, decrypt_mode));
            res_second = pfc_pkg::square_cell(square, p.row_b,
                                              pfc_pkg::step_pos(p.col_b, decrypt_mode));
        end
        if (p.col_a == p.col_b) begin
            res_first  = pfc_pkg::square_cell(square,
                                              pfc_pkg::step_pos(p.row_a, decrypt_mode),
                                              p.col_a);
            res_second = pfc_pkg::square_cell(square,
                                              pfc_pkg::step_pos(p.row_b, decrypt_mode),
                                              p.col_b);
        end
    end

    // Output register: reload whenever it is empty or being drained
    assign q_pop = q_not_empty && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next    = m_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        if (q_pop) begin
            m_valid_next    = 1'b1;
            out_first_next  = res_first;
            out_second_next = res_second;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_first  = out_first_reg;
    assign m_out_second = out_second_reg;

endmodule

FILE: hdl/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: configuration registers, front,
// queue and back. Depends on pfc_pkg, pfc_front, pfc_queue and pfc_back.
//
// Usage:
//   Input channel (s_valid/s_ready): one letter pair per request, codes 0..25.
//   Set s_lone_letter on a final single letter; in encrypt mode it is padded
//   with x. Result channel (m_valid/m_ready): one transformed pair per request.
//   Configuration: cfg_we with cfg_index 0 writes decrypt_mode, 1..5 write the
//   square rows; write only while no request is in flight.
//   Order: a pair accepted on s_* is located and written into the queue, then
//   goes through the rule logic into the result register that drives m_*.
//   Throughput: one pair per cycle while m_ready stays high.
//   Stalls: when m_ready is low the result holds, the queue of QUEUE_DEPTH
//   located pairs fills, and s_ready drops once it is full.
//   Reset: aresetn low empties queue and result register, restores the
//   default key square and selects encrypt mode; s_ready is high right after.
module playfair_digraph_cipher #(
    parameter int unsigned QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pfc_pkg::LETTER_W-1:0]       s_first_letter,
    input  logic [pfc_pkg::LETTER_W-1:0]       s_second_letter,
    input  logic                               s_lone_letter,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pfc_pkg::LETTER_W-1:0]       m_out_first,
    output logic [pfc_pkg::LETTER_W-1:0]       m_out_second,
    input  logic                               cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic               decrypt_reg;
    pfc_pkg::square_t   square_reg;
    logic               q_full, q_push, q_pop, q_not_empty;
    pfc_pkg::pair_pos_t q_wdata, q_rdata;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg   <= 1'b0;
            square_reg[0] <= pfc_pkg::SQUARE_ROW0_RST;
            square_reg[1] <= pfc_pkg::SQUARE_ROW1_RST;
            square_reg[2] <= pfc_pkg::SQUARE_ROW2_RST;
            square_reg[3] <= pfc_pkg::SQUARE_ROW3_RST;
            square_reg[4] <= pfc_pkg::SQUARE_ROW4_RST;
        end else if (cfg_we) begin
            unique case (pfc_pkg::cfg_reg_t'(cfg_index))
                pfc_pkg::CFG_DECRYPT_MODE: decrypt_reg   <= cfg_wdata[0];
                pfc_pkg::CFG_SQUARE_ROW0:  square_reg[0] <= cfg_wdata;
                pfc_pkg::CFG_SQUARE_ROW1:  square_reg[1] <= cfg_wdata;
                pfc_pkg::CFG_SQUARE_ROW2:  square_reg[2] <= cfg_wdata;
                pfc_pkg::CFG_SQUARE_ROW3:  square_reg[3] <= cfg_wdata;
                pfc_pkg::CFG_SQUARE_ROW4:  square_reg[4] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pfc_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_letter  (s_first_letter),
        .s_second_letter (s_second_letter),
        .s_lone_letter   (s_lone_letter),
        .decrypt_mode    (decrypt_reg),
        .square          (square_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    pfc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .decrypt_mode (decrypt_reg),
        .square       (square_reg),
        .q_not_empty  (q_not_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_first  (m_out_first),
        .m_out_second (m_out_second)
    );

endmodule

FILE: hdl/pfc_checker.sv
// Port-level checker for the Playfair digraph cipher, with its bind statement.
// Depends on pfc_pkg; attaches to playfair_digraph_cipher.
module pfc_checker #(
    parameter int unsigned QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [pfc_pkg::LETTER_W-1:0]   m_out_first,
    input logic [pfc_pkg::LETTER_W-1:0]   m_out_second
);

    localparam int unsigned OUT_W = $clog2(QUEUE_DEPTH + 2);

    logic [OUT_W-1:0] pending_reg;

    // Requests accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + OUT_W'(s_valid && s_ready)
                                       - OUT_W'(m_valid && m_ready);
        end
    end

    // Stalled result holds its letters
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_first) && $stable(m_out_second))
        else $error("stalled result changed");

    // Reset leaves no result and an open input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // A result is only shown for an accepted pair
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != '0)
        else $error("result without accepted pair");

    // In-flight pairs bounded by queue plus output register
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= OUT_W'(QUEUE_DEPTH + 1))
        else $error("too many pairs in flight");

endmodule

bind playfair_digraph_cipher pfc_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pfc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_first  (m_out_first),
    .m_out_second (m_out_second)
);
